// ----- rtl/tccb_pkg.sv -----
`default_nettype none

package tccb_pkg;

	localparam int COLS   = 64;
	localparam int ROWS   = 32;
	localparam int CELLS  = COLS * ROWS;
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CELL_W = $clog2(CELLS);
	localparam int PH_W   = 16;
	localparam int TK_W   = 15;
	localparam int CNT_W  = $clog2(PH_W);

	localparam logic [7:0] SPACE_CHAR   = 8'd32;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;

	typedef enum logic [2:0] {
		OP_STREAM = 3'd0,
		OP_PUT    = 3'd1,
		OP_SETCUR = 3'd2,
		OP_ERASE  = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_READ   = 3'd5,
		OP_TICK   = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		CFG_ENABLE    = 2'd0,
		CFG_ON_TICKS  = 2'd1,
		CFG_OFF_TICKS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FIN,
		ST_MOD
	} state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  ch;
		logic [15:0] color;
		logic [7:0]  col;
		logic [6:0]  row;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_char;
		logic [15:0] read_color;
		logic [5:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic        cursor_shown;
	} res_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       wr_char;
		logic [15:0]      color;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             in_range;
		logic             row_ok;
		logic             newline;
	} cmd_t;

	typedef struct packed {
		logic take;
		logic busy;
	} back_stat_t;

	function automatic logic [ROW_W-1:0] row_add(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (ROW_W+1)'(ROWS))
			s = s - (ROW_W+1)'(ROWS);
		return s[ROW_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		return CELL_W'(r) * CELL_W'(COLS) + CELL_W'(c);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tccb_front.sv -----
`default_nettype none

module tccb_front import tccb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire item_t      item,
	input  wire back_stat_t stat,
	output logic            cmd_valid,
	output cmd_t            cmd
);

	cmd_t       q_mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	cmd_t       dec;

	always_comb begin
		dec.op       = op_t'(item.func);
		dec.wr_char  = (item.ch < SPACE_CHAR) ? SPACE_CHAR : item.ch;
		dec.color    = item.color;
		dec.col      = item.col[COL_W-1:0];
		dec.row      = item.row[ROW_W-1:0];
		dec.row_ok   = {1'b0, item.row} < 8'(ROWS);
		dec.in_range = dec.row_ok && ({1'b0, item.col} < 9'(COLS));
		dec.newline  = item.ch == NEWLINE_CHAR;
	end

	assign full      = (cnt_q == 2'd2) || stat.busy;
	assign push_ok   = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok)
			q_mem[wp_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok)
				wp_q <= !wp_q;
			if (stat.take)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push_ok) - 2'(stat.take);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tccb_res_fifo.sv -----
`default_nettype none

module tccb_res_fifo import tccb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire res_t wdata,
	output logic      res_full,
	input  wire logic pop,
	output logic      empty,
	output res_t      result
);

	res_t       q_mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       pop_ok;

	assign res_full = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_ok   = pop && !empty;
	assign result   = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			q_mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (pop_ok)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(pop_ok);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tccb_back.sv -----
`default_nettype none

module tccb_back import tccb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	input  wire cmd_t       cmd,
	output back_stat_t      stat,
	input  wire logic       cfg_wr,
	input  wire logic [1:0] cfg_index,
	input  wire logic [14:0] cfg_data,
	input  wire logic       res_full,
	output logic            res_push,
	output res_t            res_data
);

	logic [7:0]  char_mem  [CELLS];
	logic [15:0] color_mem [CELLS];

	state_t            state_q, state_d;
	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [ROW_W-1:0]  top_q, top_d;
	logic [PH_W-1:0]   phase_q, phase_d;
	logic [CELL_W-1:0] sw_addr_q, sw_addr_d;
	logic [CELL_W-1:0] sw_last_q, sw_last_d;
	logic              sw_color_q, sw_color_d;
	logic              init_q, init_d;
	logic              rd_ok_q, rd_ok_d;
	logic [PH_W-1:0]   rem_q, rem_d;
	logic [PH_W-1:0]   dvd_q, dvd_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              en_q;
	logic [TK_W-1:0]   on_q, off_q;
	logic [7:0]        rchar_q;
	logic [15:0]       rcolor_q;

	logic              we_char, we_color, re;
	logic [CELL_W-1:0] waddr, raddr;
	logic [7:0]        wchar;
	logic [15:0]       wcolor;

	logic [ROW_W-1:0]  cur_phys, cmd_phys;
	logic [CELL_W-1:0] cur_addr, cmd_addr, top_base, cmd_base;
	logic [PH_W-1:0]   period;
	logic [PH_W:0]     tick_next;
	logic [PH_W:0]     step_r;
	logic [PH_W:0]     step_val;
	logic              wrap;

	assign cur_phys  = row_add(top_q, cur_row_q);
	assign cmd_phys  = row_add(top_q, cmd.row);
	assign cur_addr  = cell_addr(cur_phys, cur_col_q);
	assign cmd_addr  = cell_addr(cmd_phys, cmd.col);
	assign top_base  = cell_addr(top_q, '0);
	assign cmd_base  = cell_addr(cmd_phys, '0);
	assign period    = PH_W'(on_q) + PH_W'(off_q);
	assign tick_next = {1'b0, phase_q} + (PH_W+1)'(1);
	assign step_r    = {rem_q, dvd_q[PH_W-1]};
	assign step_val  = (step_r >= {1'b0, period}) ? step_r - {1'b0, period} : step_r;

	always_comb begin
		state_d    = state_q;
		cur_col_d  = cur_col_q;
		cur_row_d  = cur_row_q;
		top_d      = top_q;
		phase_d    = phase_q;
		sw_addr_d  = sw_addr_q;
		sw_last_d  = sw_last_q;
		sw_color_d = sw_color_q;
		init_d     = init_q;
		rd_ok_d    = rd_ok_q;
		rem_d      = rem_q;
		dvd_d      = dvd_q;
		cnt_d      = cnt_q;
		we_char    = 1'b0;
		we_color   = 1'b0;
		waddr      = cur_addr;
		wchar      = SPACE_CHAR;
		wcolor     = '0;
		re         = 1'b0;
		raddr      = cmd_addr;
		stat.take  = 1'b0;
		stat.busy  = init_q;
		res_push   = 1'b0;
		wrap       = 1'b0;

		res_data.read_char    = rd_ok_q ? rchar_q : 8'd0;
		res_data.read_color   = rd_ok_q ? rcolor_q : 16'd0;
		res_data.cursor_col   = 6'(cur_col_q);
		res_data.cursor_row   = 5'(cur_row_q);
		res_data.cursor_shown = en_q && (period != '0) && (phase_q < PH_W'(on_q));

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_full) begin
					stat.take = 1'b1;
					state_d   = ST_FIN;
					rd_ok_d   = 1'b0;
					case (cmd.op)
						OP_STREAM: begin
							phase_d = '0;
							if (cmd.newline) begin
								wrap = 1'b1;
							end else begin
								we_char  = 1'b1;
								we_color = 1'b1;
								waddr    = cur_addr;
								wchar    = cmd.wr_char;
								wcolor   = cmd.color;
								wrap     = cur_col_q == COL_W'(COLS - 1);
								cur_col_d = cur_col_q + COL_W'(1);
							end
							if (wrap) begin
								cur_col_d = '0;
								if (cur_row_q == ROW_W'(ROWS - 1)) begin
									sw_addr_d  = top_base;
									sw_last_d  = top_base + CELL_W'(COLS - 1);
									sw_color_d = 1'b1;
									top_d      = row_add(top_q, ROW_W'(1));
									state_d    = ST_SWEEP;
								end else begin
									cur_row_d = cur_row_q + ROW_W'(1);
								end
							end
						end
						OP_PUT: begin
							if (cmd.in_range) begin
								we_char  = 1'b1;
								we_color = 1'b1;
								waddr    = cmd_addr;
								wchar    = cmd.wr_char;
								wcolor   = cmd.color;
							end
						end
						OP_SETCUR: begin
							if (cmd.in_range) begin
								cur_col_d = cmd.col;
								cur_row_d = cmd.row;
								phase_d   = '0;
							end
						end
						OP_ERASE: begin
							if (cmd.row_ok) begin
								sw_addr_d  = cmd_base;
								sw_last_d  = cmd_base + CELL_W'(COLS - 1);
								sw_color_d = 1'b0;
								state_d    = ST_SWEEP;
							end
						end
						OP_CLEAR: begin
							cur_col_d  = '0;
							cur_row_d  = '0;
							top_d      = '0;
							sw_addr_d  = '0;
							sw_last_d  = CELL_W'(CELLS - 1);
							sw_color_d = 1'b1;
							state_d    = ST_SWEEP;
						end
						OP_READ: begin
							if (cmd.in_range) begin
								re      = 1'b1;
								raddr   = cmd_addr;
								rd_ok_d = 1'b1;
							end
						end
						OP_TICK: begin
							if ((period == '0) || (tick_next >= {1'b0, period}))
								phase_d = '0;
							else
								phase_d = tick_next[PH_W-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			ST_SWEEP: begin
				we_char   = 1'b1;
				we_color  = sw_color_q;
				waddr     = sw_addr_q;
				sw_addr_d = sw_addr_q + CELL_W'(1);
				if (sw_addr_q == sw_last_q) begin
					state_d = init_q ? ST_IDLE : ST_FIN;
					init_d  = 1'b0;
				end
			end
			ST_FIN: begin
				if (en_q && (period != '0) && (phase_q >= period)) begin
					rem_d   = '0;
					dvd_d   = phase_q;
					cnt_d   = '1;
					state_d = ST_MOD;
				end else begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_MOD: begin
				rem_d = step_val[PH_W-1:0];
				dvd_d = dvd_q << 1;
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					res_data.cursor_shown = step_val < (PH_W+1)'(on_q);
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_SWEEP;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			top_q      <= '0;
			phase_q    <= '0;
			sw_addr_q  <= '0;
			sw_last_q  <= CELL_W'(CELLS - 1);
			sw_color_q <= 1'b1;
			init_q     <= 1'b1;
			rd_ok_q    <= 1'b0;
			cnt_q      <= '0;
		end else begin
			cur_col_q  <= cur_col_d;
			cur_row_q  <= cur_row_d;
			top_q      <= top_d;
			phase_q    <= phase_d;
			sw_addr_q  <= sw_addr_d;
			sw_last_q  <= sw_last_d;
			sw_color_q <= sw_color_d;
			init_q     <= init_d;
			rd_ok_q    <= rd_ok_d;
			cnt_q      <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		dvd_q <= dvd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b1;
			on_q  <= TK_W'(500);
			off_q <= TK_W'(500);
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_ENABLE:    en_q  <= cfg_data[0];
				CFG_ON_TICKS:  on_q  <= cfg_data;
				CFG_OFF_TICKS: off_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we_char)
			char_mem[waddr] <= wchar;
		if (we_color)
			color_mem[waddr] <= wcolor;
		if (re) begin
			rchar_q  <= char_mem[raddr];
			rcolor_q <= color_mem[raddr];
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into full queue");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.take |-> (cmd_valid && state_q == ST_IDLE && !init_q))
		else $error("command taken while none waiting or busy");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && sw_addr_q == sw_last_q && !init_q) |=> state_q == ST_FIN)
		else $error("sweep did not finish into result stage");

	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD && cnt_q == '0) |-> res_push)
		else $error("remainder finished without result");

endmodule

`default_nettype wire

// ----- rtl/text_console_cell_buffer.sv -----
// text console cell buffer: character and color cell store with cursor and blink
//
// commands enter through a queue-style port: item is transferred when push is
// high and full is low. every command gives exactly one result, shown on result
// while empty is low and transferred when pop is high.
// registers (cursor_enable, cursor_on_ticks, cursor_off_ticks) are written on
// the cfg port (cfg_valid/cfg_ready, cfg_index, cfg_data) while the block is
// idle: a rule for the user that the block does not enforce. a plain command
// passes the command queue, the sequencer and its result stage into the
// result queue; the sequencer takes one command at a time. scroll and erase
// line sweep one line of the store, one cell a cycle; clear sweeps all 2048
// cells. with the cursor enabled and the blink phase at or beyond a shortened
// period, a bit-serial remainder pass comes before the result. reset starts
// a clearing pass over all 2048 cells of the store; full stays high until it
// ends. register writes are taken at any time. if the receiver stops popping,
// two results and two commands are held, then full rises; nothing is dropped.

`default_nettype none

module text_console_cell_buffer import tccb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire item_t       item,
	output logic             empty,
	input  wire logic        pop,
	output res_t             result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	back_stat_t stat;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       res_full;
	logic       res_push;
	res_t       res_data;
	logic       cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	tccb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.stat      (stat),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	tccb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	tccb_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res_push),
		.wdata    (res_data),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

`default_nettype wire
